/* sv/assert_macros.svh */
// assertion macros used by the top-level rtl file of the proximity auto-lock block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// concurrent check that is switched off while reset is asserted
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// concurrent check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* sv/rpal_pkg.sv */
// types, codes and constants of the proximity auto-lock block
`default_nettype none

package rpal_pkg;

  // default number of connection slots
  localparam int CONNECTIONS_DEF = 16;
  // samples per median window
  localparam int WINDOW = 5;

  // configuration register indexes
  localparam logic [1:0] CFG_IMM_THR  = 2'd0;
  localparam logic [1:0] CFG_FAR_THR  = 2'd1;
  localparam logic [1:0] CFG_HOLD     = 2'd2;

  // configuration reset values
  localparam logic [7:0] IMM_THR_RST = 8'hC4;  // -60
  localparam logic [7:0] FAR_THR_RST = 8'hB0;  // -80
  localparam logic [7:0] HOLD_RST    = 8'd5;

  // lock state codes on the input
  localparam logic [1:0] LOCK_LOCKED   = 2'd0;
  localparam logic [1:0] LOCK_UNLOCKED = 2'd1;

  typedef enum logic [1:0] {
    ZONE_IMMEDIATE = 2'd0,
    ZONE_NEAR      = 2'd1,
    ZONE_FAR       = 2'd2,
    ZONE_NONE      = 2'd3
  } zone_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_LOCK   = 2'd1,
    ACT_UNLOCK = 2'd2
  } action_e;

  typedef logic signed [7:0] rssi_t;

  // one connection slot: sample ring plus tracking state
  typedef struct packed {
    logic [WINDOW-1:0][7:0] win;
    logic [2:0]             fill;
    logic [2:0]             pos;
    zone_e                  last_zone;
    logic [7:0]             dwell;
  } row_t;

  // one result item
  typedef struct packed {
    zone_e   zone;
    rssi_t   filt;
    action_e action;
  } res_t;

endpackage

`default_nettype wire

/* sv/rssi_proximity_auto_lock.sv */
// top level of the rssi proximity auto-lock block
//
// Input channel (in_valid_i/in_ready_o) carries one rssi sample per
// transaction with its connection slot, auth flag and current lock state.
// Output channel (out_valid_o/out_ready_i) returns exactly one result per
// input: slot, zone, median-filtered rssi and lock/unlock request.
// Throughput is one transaction per cycle, for any mix of slots, while the
// output is not stalled. A sample is taken into one input stage that also
// reads the slot row from memory, then goes through the median/zone/dwell
// logic into the output register.
// Per-slot state lives in a row memory of CONNECTIONS rows; back-to-back
// samples of the same slot see the row just written through forwarding.
// Reset clears the row valid bits at once, so every slot starts empty with
// no zone; the thresholds and hold return to -60, -80 and 5. No clearing
// pass is needed. When the receiver stalls, the result waits in the output
// register, one more sample is taken into the input stage, and then
// in_ready_o drops until the output drains.
// Configuration writes (cfg_we_i) take effect at once; the user must make
// them only while the block is idle, as the block does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module rssi_proximity_auto_lock #(
  parameter int CONNECTIONS = rpal_pkg::CONNECTIONS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration write port
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i,
  // sample input
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [3:0] conn_id_i,
  input  wire logic signed [7:0] rssi_sample_i,
  input  wire logic       auth_ok_i,
  input  wire logic [1:0] lock_state_i,
  // result output
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [3:0]      conn_out_o,
  output logic [1:0]      zone_o,
  output logic signed [7:0] filtered_rssi_o,
  output logic [1:0]      action_o
);
  import rpal_pkg::*;

  localparam int AW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

  // configuration registers
  rssi_t      imm_thr_q;
  rssi_t      far_thr_q;
  logic [7:0] hold_q;

  // input stage
  logic       a_vld_q;
  logic [3:0] a_conn_q;
  rssi_t      a_sample_q;
  logic       a_auth_q;
  logic [1:0] a_lock_q;

  // output register
  logic       out_vld_q;
  logic [3:0] out_conn_q;
  res_t       out_res_q;

  logic          a_adv;
  logic          in_acc;
  logic          in_rng;
  logic          a_rng;
  logic          wr_en;
  logic [AW+3:0] in_conn_ext;
  logic [AW+3:0] a_conn_ext;
  row_t          rd_row;
  row_t          wr_row;
  res_t          res;

  // handshake: the input stage moves on whenever the output register is free
  assign a_adv      = !out_vld_q || out_ready_i;
  assign in_ready_o = !a_vld_q || a_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // slot range and row addresses
  assign in_conn_ext = {{AW{1'b0}}, conn_id_i};
  assign a_conn_ext  = {{AW{1'b0}}, a_conn_q};
  assign in_rng      = ({28'd0, conn_id_i} < 32'(CONNECTIONS));
  assign a_rng       = ({28'd0, a_conn_q} < 32'(CONNECTIONS));
  assign wr_en       = a_vld_q && a_adv && a_rng;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imm_thr_q <= IMM_THR_RST;
      far_thr_q <= FAR_THR_RST;
      hold_q    <= HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMM_THR: imm_thr_q <= cfg_wdata_i;
        CFG_FAR_THR: far_thr_q <= cfg_wdata_i;
        CFG_HOLD:    hold_q    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        a_vld_q <= in_valid_i;
      end
      if (a_adv) begin
        out_vld_q <= a_vld_q;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_conn_q   <= conn_id_i;
      a_sample_q <= rssi_sample_i;
      a_auth_q   <= auth_ok_i;
      a_lock_q   <= lock_state_i;
    end
    if (a_vld_q && a_adv) begin
      out_conn_q <= a_conn_q;
      if (a_rng) begin
        out_res_q <= res;
      end else begin
        out_res_q.zone   <= ZONE_FAR;
        out_res_q.filt   <= a_sample_q;
        out_res_q.action <= ACT_NONE;
      end
    end
  end

  // per-slot row storage
  rpal_row_store #(
    .CONNECTIONS(CONNECTIONS),
    .AW         (AW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_acc && in_rng),
    .rd_addr_i(in_conn_ext[AW-1:0]),
    .wr_en_i  (wr_en),
    .wr_addr_i(a_conn_ext[AW-1:0]),
    .wr_row_i (wr_row),
    .rd_row_o (rd_row)
  );

  // filter, zone and dwell logic
  rpal_update u_update (
    .row_i    (rd_row),
    .sample_i (a_sample_q),
    .auth_i   (a_auth_q),
    .lock_i   (a_lock_q),
    .imm_thr_i(imm_thr_q),
    .far_thr_i(far_thr_q),
    .hold_i   (hold_q),
    .row_o    (wr_row),
    .res_o    (res)
  );

  // outputs
  assign out_valid_o     = out_vld_q;
  assign conn_out_o      = out_conn_q;
  assign zone_o          = out_res_q.zone;
  assign filtered_rssi_o = out_res_q.filt;
  assign action_o        = out_res_q.action;

  // checks
  `ASSERT_RST(a_unlock_imm, clk_i, rst_ni, (out_vld_q && (out_res_q.action == ACT_UNLOCK)) |-> (out_res_q.zone == ZONE_IMMEDIATE), "unlock outside immediate zone")
  `ASSERT_RST(a_lock_not_imm, clk_i, rst_ni, (out_vld_q && (out_res_q.action == ACT_LOCK)) |-> (out_res_q.zone != ZONE_IMMEDIATE), "lock in immediate zone")
  `ASSERT_RST(a_zone_known, clk_i, rst_ni, out_vld_q |-> (out_res_q.zone != ZONE_NONE), "result with no zone")
  `ASSERT_RST(a_stage_held, clk_i, rst_ni, (a_vld_q && !a_adv) |=> a_vld_q, "input stage dropped while stalled")
  `ASSERT_ALWAYS(a_no_write_idle, clk_i, wr_en |-> a_vld_q, "row written with no item in flight")

endmodule

`default_nettype wire

/* sv/rpal_row_store.sv */
// per-connection row memory with valid bits and write-to-read forwarding
`default_nettype none

module rpal_row_store #(
  parameter int CONNECTIONS = rpal_pkg::CONNECTIONS_DEF,
  parameter int AW          = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire rpal_pkg::row_t wr_row_i,
  output rpal_pkg::row_t     rd_row_o
);
  import rpal_pkg::*;

  row_t                   mem [CONNECTIONS];
  row_t                   mem_rd_q;
  row_t                   fwd_row_q;
  logic                   fwd_q;
  logic                   rd_vld_q;
  logic [CONNECTIONS-1:0] row_vld_q;
  logic                   hit;
  row_t                   raw_row;

  // a write to the address being read in the same cycle is forwarded
  assign hit = wr_en_i && (wr_addr_i == rd_addr_i);

  // row memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      mem_rd_q  <= mem[rd_addr_i];
      fwd_row_q <= wr_row_i;
    end
  end

  // valid bits and read tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_addr_i] || hit;
        fwd_q    <= hit;
      end
    end
  end

  // a row never written reads back with its reset tracking state
  always_comb begin
    raw_row  = fwd_q ? fwd_row_q : mem_rd_q;
    rd_row_o = raw_row;
    if (!rd_vld_q) begin
      rd_row_o.fill      = 3'd0;
      rd_row_o.pos       = 3'd0;
      rd_row_o.last_zone = ZONE_NONE;
      rd_row_o.dwell     = 8'd0;
    end
  end

endmodule

`default_nettype wire

/* sv/rpal_update.sv */
// ring update, median of five, zone classification and dwell/action logic
`default_nettype none

module rpal_update (
  input  wire rpal_pkg::row_t  row_i,
  input  wire rpal_pkg::rssi_t sample_i,
  input  wire logic            auth_i,
  input  wire logic [1:0]      lock_i,
  input  wire rpal_pkg::rssi_t imm_thr_i,
  input  wire rpal_pkg::rssi_t far_thr_i,
  input  wire logic [7:0]      hold_i,
  output rpal_pkg::row_t       row_o,
  output rpal_pkg::res_t       res_o
);
  import rpal_pkg::*;

  logic [2:0]             p;
  logic [2:0]             fill_n;
  logic [7:0]             dwell_n;
  logic [WINDOW-1:0][7:0] win;
  logic [2:0]             rank [WINDOW];
  rssi_t                  med;
  zone_e                  zone;

  // write the sample into the ring and advance pointer and fill count
  always_comb begin
    p      = (row_i.pos >= 3'(WINDOW)) ? 3'd0 : row_i.pos;
    win    = row_i.win;
    win[p] = sample_i;
    fill_n = (row_i.fill < 3'(WINDOW)) ? row_i.fill + 3'd1 : row_i.fill;
  end

  // median by rank: ties broken by position so exactly one entry has rank two
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = 3'd0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j != i) begin
          if (($signed(win[j]) < $signed(win[i])) || ((win[j] == win[i]) && (j < i))) begin
            rank[i] = rank[i] + 3'd1;
          end
        end
      end
    end
    med = rssi_t'(win[0]);
    for (int i = 0; i < WINDOW; i++) begin
      if (rank[i] == 3'(WINDOW / 2)) begin
        med = rssi_t'(win[i]);
      end
    end
  end

  // zone against the two thresholds
  always_comb begin
    priority if (med > imm_thr_i) begin
      zone = ZONE_IMMEDIATE;
    end else if (med > far_thr_i) begin
      zone = ZONE_NEAR;
    end else begin
      zone = ZONE_FAR;
    end
  end

  // dwell tracking and lock action
  always_comb begin
    row_o       = row_i;
    row_o.win   = win;
    row_o.fill  = fill_n;
    row_o.pos   = (p == 3'(WINDOW - 1)) ? 3'd0 : p + 3'd1;
    res_o.zone   = ZONE_FAR;
    res_o.filt   = sample_i;
    res_o.action = ACT_NONE;
    dwell_n      = (row_i.dwell < hold_i) ? row_i.dwell + 8'd1 : row_i.dwell;
    if (fill_n >= 3'(WINDOW)) begin
      res_o.zone = zone;
      res_o.filt = med;
      if (auth_i) begin
        if (zone == row_i.last_zone) begin
          row_o.dwell = dwell_n;
          if (dwell_n == hold_i) begin
            if ((zone == ZONE_IMMEDIATE) && (lock_i == LOCK_LOCKED)) begin
              res_o.action = ACT_UNLOCK;
            end else if ((zone != ZONE_IMMEDIATE) && (lock_i == LOCK_UNLOCKED)) begin
              res_o.action = ACT_LOCK;
            end
          end
        end else begin
          row_o.last_zone = zone;
          row_o.dwell     = 8'd0;
        end
      end
    end
  end

endmodule

`default_nettype wire
